// ===== design/mutf7_pkg.sv =====
// shared types, constants and helpers for the modified utf-7 to utf-8 decoder
package mutf7_pkg;

    localparam int RUN_DEPTH_DEF = 32;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    localparam logic [7:0] UTF_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF_LEAD4 = 8'hF0;
    localparam logic [7:0] UTF_CONT  = 8'h80;

    localparam logic [15:0] SUR_HI_MIN = 16'hD800;
    localparam logic [15:0] SUR_HI_MAX = 16'hDBFF;
    localparam logic [15:0] SUR_LO_MIN = 16'hDC00;
    localparam logic [15:0] SUR_LO_MAX = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_BYTE,
        ACT_CP,
        ACT_REPLAY
    } act_t;

    typedef enum logic [2:0] {
        SRC_STEP,
        SRC_BARE,
        SRC_UTF,
        SRC_RAM,
        SRC_DASH
    } src_t;

    typedef struct packed {
        act_t       act;
        logic       slot_free;
        logic [2:0] utf_len;
        logic       dash;
        logic       last;
    } dp_status_t;

    typedef struct packed {
        logic       accept;
        logic       push;
        src_t       src;
        logic       out_last;
        logic [1:0] utf_idx;
    } ctrl_cmd_t;

    // {valid, value}
    function automatic logic [6:0] b64_decode(input logic [7:0] c);
        logic [6:0] r;
        r = '0;
        if (c inside {[8'h41:8'h5A]})
        begin
            r = {1'b1, 6'(c - 8'h41)};
        end
        else if (c inside {[8'h61:8'h7A]})
        begin
            r = {1'b1, 6'(c - 8'h61 + 8'd26)};
        end
        else if (c inside {[8'h30:8'h39]})
        begin
            r = {1'b1, 6'(c - 8'h30 + 8'd52)};
        end
        else if (c == CH_PLUS)
        begin
            r = {1'b1, 6'd62};
        end
        else if (c == CH_COMMA)
        begin
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

    function automatic logic [2:0] utf8_len(input logic [20:0] cp);
        logic [2:0] n;
        if (cp < 21'h80)
        begin
            n = 3'd1;
        end
        else if (cp < 21'h800)
        begin
            n = 3'd2;
        end
        else if (cp < SUPP_BASE)
        begin
            n = 3'd3;
        end
        else
        begin
            n = 3'd4;
        end
        return n;
    endfunction

endpackage

// ===== design/mutf7_ram.sv =====
// generic single-write single-read ram with registered read data
module mutf7_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/mutf7_dp.sv =====
// datapath: base64 run decoding, surrogate joining, raw run store, output register
module mutf7_dp #(
    parameter int RUN_DEPTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [7:0]                         in_byte,
    input  logic                               in_last,
    input  logic                               out_ready,
    input  mutf7_pkg::ctrl_cmd_t               cmd,
    input  logic [$clog2(RUN_DEPTH+2)-1:0]     rep_idx,
    output mutf7_pkg::dp_status_t              status,
    output logic [$clog2(RUN_DEPTH+2)-1:0]     rep_n,
    output logic                               out_valid,
    output logic [7:0]                         out_byte,
    output logic                               byte_valid,
    output logic                               out_last,
    output logic                               raw_overflow
);

    import mutf7_pkg::*;

    localparam int LEN_W = $clog2(RUN_DEPTH + 2);
    localparam int AW    = $clog2(RUN_DEPTH);
    localparam logic [LEN_W-1:0] DEPTH_L  = LEN_W'(RUN_DEPTH);
    localparam logic [LEN_W-1:0] OVF_MARK = LEN_W'(RUN_DEPTH + 1);

    typedef enum logic [2:0] {
        MODE_DIRECT = 3'b001,
        MODE_AMP    = 3'b010,
        MODE_RUN    = 3'b100
    } mode_t;

    mode_t             mode_reg, mode_next;
    logic [21:0]       acc_reg, acc_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [9:0]        hs_reg, hs_next;
    logic              hp_reg, hp_next;
    logic              inv_reg, inv_next;
    logic [LEN_W-1:0]  raw_len_reg, raw_len_next;
    logic              ovf_seen_reg, ovf_seen_next;

    logic [20:0]       cp_reg;
    logic [2:0]        len_reg;
    logic [LEN_W-1:0]  rep_n_reg;
    logic              dash_reg;
    logic              last_reg;
    logic              ovf_emit_reg;

    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              byte_valid_reg;
    logic              out_last_reg;
    logic              raw_ovf_reg;

    act_t              act;
    logic [7:0]        step_byte;
    logic [20:0]       cp;
    logic [LEN_W-1:0]  rep_cnt;
    logic              rep_dash;
    logic              end_run;
    logic              dash_end;
    logic              set_ovf;
    logic              step_ovf;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [7:0]        wdata;
    logic [6:0]        b64;
    logic [21:0]       acc_shift;
    logic [4:0]        cnt_sum;
    logic [4:0]        cnt_rem;
    logic [15:0]       unit;
    logic              is_hi;
    logic              is_lo;
    logic [20:0]       cp_pair;
    logic [7:0]        rd_data;
    logic [7:0]        utf_byte;
    logic [7:0]        mux_byte;
    logic              mux_bv;
    logic              mux_ovf;

    assign b64       = b64_decode(in_byte);
    assign acc_shift = {acc_reg[15:0], b64[5:0]};
    assign cnt_sum   = cnt_reg + 5'd6;
    assign cnt_rem   = cnt_sum - 5'd16;
    assign unit      = 16'(acc_shift >> cnt_rem);
    assign is_hi     = (unit >= SUR_HI_MIN) && (unit <= SUR_HI_MAX);
    assign is_lo     = (unit >= SUR_LO_MIN) && (unit <= SUR_LO_MAX);
    assign cp_pair   = SUPP_BASE + {1'b0, hs_reg, unit[9:0]};

    always_comb
    begin
        mode_next     = mode_reg;
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        hs_next       = hs_reg;
        hp_next       = hp_reg;
        inv_next      = inv_reg;
        raw_len_next  = raw_len_reg;
        ovf_seen_next = ovf_seen_reg;
        act           = ACT_NONE;
        step_byte     = in_byte;
        cp            = {5'b0, unit};
        rep_cnt       = raw_len_reg;
        rep_dash      = 1'b0;
        end_run       = 1'b0;
        dash_end      = 1'b0;
        set_ovf       = 1'b0;
        we            = 1'b0;
        waddr         = raw_len_reg[AW-1:0];
        wdata         = in_byte;

        case (mode_reg)
            MODE_DIRECT:
            begin
                if (in_byte == CH_AMP)
                begin
                    mode_next    = MODE_AMP;
                    acc_next     = '0;
                    cnt_next     = '0;
                    hs_next      = '0;
                    hp_next      = 1'b0;
                    inv_next     = 1'b0;
                    we           = 1'b1;
                    waddr        = '0;
                    wdata        = CH_AMP;
                    raw_len_next = LEN_W'(1);
                end
                else
                begin
                    act = ACT_BYTE;
                end
            end
            default:
            begin
                if (in_byte == CH_DASH && mode_reg == MODE_AMP)
                begin
                    act          = ACT_BYTE;
                    step_byte    = CH_AMP;
                    mode_next    = MODE_DIRECT;
                    raw_len_next = '0;
                end
                else if (in_byte == CH_DASH)
                begin
                    end_run  = 1'b1;
                    dash_end = 1'b1;
                end
                else
                begin
                    mode_next = MODE_RUN;
                    if (raw_len_reg < DEPTH_L)
                    begin
                        we           = 1'b1;
                        raw_len_next = raw_len_reg + 1'b1;
                    end
                    else
                    begin
                        raw_len_next = OVF_MARK;
                    end
                    if (!inv_reg)
                    begin
                        if (!b64[6])
                        begin
                            inv_next = 1'b1;
                        end
                        else
                        begin
                            acc_next = acc_shift;
                            cnt_next = cnt_sum;
                            if (cnt_sum >= 5'd16)
                            begin
                                cnt_next = cnt_rem;
                                if (is_hi)
                                begin
                                    hs_next = unit[9:0];
                                    hp_next = 1'b1;
                                end
                                else
                                begin
                                    act     = ACT_CP;
                                    cp      = (is_lo && hp_reg) ? cp_pair : {5'b0, unit};
                                    hs_next = '0;
                                    hp_next = 1'b0;
                                end
                            end
                        end
                    end
                    end_run = in_last;
                end
            end
        endcase

        if (end_run)
        begin
            if (inv_next)
            begin
                act      = ACT_REPLAY;
                rep_dash = dash_end;
                if (raw_len_next > DEPTH_L)
                begin
                    set_ovf = 1'b1;
                    rep_cnt = DEPTH_L;
                end
                else
                begin
                    rep_cnt = raw_len_next;
                end
            end
            mode_next    = MODE_DIRECT;
            acc_next     = '0;
            cnt_next     = '0;
            hs_next      = '0;
            hp_next      = 1'b0;
            inv_next     = 1'b0;
            raw_len_next = '0;
        end

        step_ovf      = ovf_seen_reg | set_ovf;
        ovf_seen_next = step_ovf;

        if (in_last)
        begin
            mode_next     = MODE_DIRECT;
            acc_next      = '0;
            cnt_next      = '0;
            hs_next       = '0;
            hp_next       = 1'b0;
            inv_next      = 1'b0;
            raw_len_next  = '0;
            ovf_seen_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_DIRECT;
            acc_reg      <= '0;
            cnt_reg      <= '0;
            hs_reg       <= '0;
            hp_reg       <= 1'b0;
            inv_reg      <= 1'b0;
            raw_len_reg  <= '0;
            ovf_seen_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            mode_reg     <= mode_next;
            acc_reg      <= acc_next;
            cnt_reg      <= cnt_next;
            hs_reg       <= hs_next;
            hp_reg       <= hp_next;
            inv_reg      <= inv_next;
            raw_len_reg  <= raw_len_next;
            ovf_seen_reg <= ovf_seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cp_reg       <= cp;
            len_reg      <= utf8_len(cp);
            rep_n_reg    <= rep_cnt;
            dash_reg     <= rep_dash;
            last_reg     <= in_last;
            ovf_emit_reg <= step_ovf;
        end
    end

    mutf7_ram #(
        .WIDTH (8),
        .DEPTH (RUN_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.accept & we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (rep_idx[AW-1:0]),
        .rdata (rd_data)
    );

    always_comb
    begin
        case (len_reg)
            3'd1:
            begin
                utf_byte = cp_reg[7:0];
            end
            3'd2:
            begin
                if (cmd.utf_idx == 2'd0)
                begin
                    utf_byte = UTF_LEAD2 | {3'b0, cp_reg[10:6]};
                end
                else
                begin
                    utf_byte = UTF_CONT | {2'b0, cp_reg[5:0]};
                end
            end
            3'd3:
            begin
                case (cmd.utf_idx)
                    2'd0:    utf_byte = UTF_LEAD3 | {4'b0, cp_reg[15:12]};
                    2'd1:    utf_byte = UTF_CONT | {2'b0, cp_reg[11:6]};
                    default: utf_byte = UTF_CONT | {2'b0, cp_reg[5:0]};
                endcase
            end
            default:
            begin
                case (cmd.utf_idx)
                    2'd0:    utf_byte = UTF_LEAD4 | {5'b0, cp_reg[20:18]};
                    2'd1:    utf_byte = UTF_CONT | {2'b0, cp_reg[17:12]};
                    2'd2:    utf_byte = UTF_CONT | {2'b0, cp_reg[11:6]};
                    default: utf_byte = UTF_CONT | {2'b0, cp_reg[5:0]};
                endcase
            end
        endcase
    end

    always_comb
    begin
        case (cmd.src)
            SRC_STEP:
            begin
                mux_byte = step_byte;
                mux_bv   = 1'b1;
                mux_ovf  = step_ovf;
            end
            SRC_UTF:
            begin
                mux_byte = utf_byte;
                mux_bv   = 1'b1;
                mux_ovf  = ovf_emit_reg;
            end
            SRC_RAM:
            begin
                mux_byte = rd_data;
                mux_bv   = 1'b1;
                mux_ovf  = ovf_emit_reg;
            end
            SRC_DASH:
            begin
                mux_byte = CH_DASH;
                mux_bv   = 1'b1;
                mux_ovf  = ovf_emit_reg;
            end
            default:
            begin
                mux_byte = '0;
                mux_bv   = 1'b0;
                mux_ovf  = step_ovf;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            out_byte_reg   <= mux_byte;
            byte_valid_reg <= mux_bv;
            out_last_reg   <= cmd.out_last;
            raw_ovf_reg    <= mux_ovf;
        end
    end

    assign status.act       = act;
    assign status.slot_free = !out_valid_reg || out_ready;
    assign status.utf_len   = len_reg;
    assign status.dash      = dash_reg;
    assign status.last      = last_reg;
    assign rep_n            = rep_n_reg;

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign byte_valid   = byte_valid_reg;
    assign out_last     = out_last_reg;
    assign raw_overflow = raw_ovf_reg;

endmodule

// ===== design/mutf7_ctrl.sv =====
// controller: request acceptance and sequencing of utf-8, replay and end-mark results
module mutf7_ctrl #(
    parameter int RUN_DEPTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_last,
    output logic                               in_ready,
    input  mutf7_pkg::dp_status_t              status,
    input  logic [$clog2(RUN_DEPTH+2)-1:0]     rep_n,
    output mutf7_pkg::ctrl_cmd_t               cmd,
    output logic [$clog2(RUN_DEPTH+2)-1:0]     rep_idx
);

    import mutf7_pkg::*;

    localparam int LEN_W = $clog2(RUN_DEPTH + 2);

    typedef enum logic [4:0] {
        S_IN    = 5'b00001,
        S_UTF   = 5'b00010,
        S_RADDR = 5'b00100,
        S_RDATA = 5'b01000,
        S_DASH  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [1:0]        idx_reg, idx_next;
    logic [LEN_W-1:0]  k_reg, k_next;

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        k_next       = k_reg;
        in_ready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.push     = 1'b0;
        cmd.src      = SRC_STEP;
        cmd.out_last = 1'b0;
        cmd.utf_idx  = idx_reg;

        case (state_reg)
            S_IN:
            begin
                in_ready = status.slot_free;
                if (in_valid && status.slot_free)
                begin
                    cmd.accept = 1'b1;
                    case (status.act)
                        ACT_BYTE:
                        begin
                            cmd.push     = 1'b1;
                            cmd.src      = SRC_STEP;
                            cmd.out_last = in_last;
                        end
                        ACT_CP:
                        begin
                            state_next = S_UTF;
                            idx_next   = '0;
                        end
                        ACT_REPLAY:
                        begin
                            state_next = S_RADDR;
                            k_next     = '0;
                        end
                        default:
                        begin
                            cmd.push     = in_last;
                            cmd.src      = SRC_BARE;
                            cmd.out_last = 1'b1;
                        end
                    endcase
                end
            end
            S_UTF:
            begin
                if (status.slot_free)
                begin
                    cmd.push = 1'b1;
                    cmd.src  = SRC_UTF;
                    if ({1'b0, idx_reg} + 3'd1 == status.utf_len)
                    begin
                        cmd.out_last = status.last;
                        state_next   = S_IN;
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
            end
            S_RADDR:
            begin
                state_next = S_RDATA;
            end
            S_RDATA:
            begin
                if (status.slot_free)
                begin
                    cmd.push = 1'b1;
                    cmd.src  = SRC_RAM;
                    if (k_reg + 1'b1 == rep_n)
                    begin
                        if (status.dash)
                        begin
                            state_next = S_DASH;
                        end
                        else
                        begin
                            cmd.out_last = status.last;
                            state_next   = S_IN;
                        end
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_RADDR;
                    end
                end
            end
            S_DASH:
            begin
                if (status.slot_free)
                begin
                    cmd.push     = 1'b1;
                    cmd.src      = SRC_DASH;
                    cmd.out_last = status.last;
                    state_next   = S_IN;
                end
            end
            default:
            begin
                state_next = S_IN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IN;
            idx_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            k_reg     <= k_next;
        end
    end

    assign rep_idx = k_reg;

endmodule

// ===== design/modified_utf7_to_utf8_decoder_unit.sv =====
// top level of the modified utf-7 to utf-8 mailbox name decoder
// a result is registered in the output register in the cycle after it is pushed
// throughput: one request per cycle when it passes through or gives no data and the output is not stalled
// a decoded code point is pushed as its one to four utf-8 bytes from S_UTF, each when the slot is free
// invalid run: each stored byte via S_RADDR and S_RDATA (ram read), then a closing dash via S_DASH
// reset: rst_n clears the decode state and output valid at once; the run ram is not cleared
module modified_utf7_to_utf8_decoder_unit #(
    parameter int RUN_DEPTH = mutf7_pkg::RUN_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       out_last,
    output logic       raw_overflow
);

    import mutf7_pkg::*;

    localparam int LEN_W = $clog2(RUN_DEPTH + 2);

    dp_status_t        status;
    ctrl_cmd_t         cmd;
    logic [LEN_W-1:0]  rep_n;
    logic [LEN_W-1:0]  rep_idx;

    mutf7_ctrl #(
        .RUN_DEPTH (RUN_DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_last  (in_last),
        .in_ready (in_ready),
        .status   (status),
        .rep_n    (rep_n),
        .cmd      (cmd),
        .rep_idx  (rep_idx)
    );

    mutf7_dp #(
        .RUN_DEPTH (RUN_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_byte      (in_byte),
        .in_last      (in_last),
        .out_ready    (out_ready),
        .cmd          (cmd),
        .rep_idx      (rep_idx),
        .status       (status),
        .rep_n        (rep_n),
        .out_valid    (out_valid),
        .out_byte     (out_byte),
        .byte_valid   (byte_valid),
        .out_last     (out_last),
        .raw_overflow (raw_overflow)
    );

endmodule

// ===== design/mutf7_checker.sv =====
// port-level checker for the decoder and its bind to the top level
module mutf7_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       byte_valid,
    input logic       out_last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last)
            && $stable(byte_valid))
        else $error("stalled result changed");

    // a bare marker is always the end of a name and carries a zero byte
    a_bare_mark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> out_last && out_byte == 8'h00)
        else $error("bare marker not final or not zero");

    // no new request while the output register is full and stalled
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("request taken while output stalled");

endmodule

bind modified_utf7_to_utf8_decoder_unit mutf7_checker u_mutf7_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .out_last   (out_last)
);
